FILE: hw/rtl/mrms_pkg.sv
// Shared constants, request codes and table port structs for the Modbus
// register map server. No dependencies; imported by mrms_tables and the top.
`default_nettype none

package mrms_pkg;

  // Table geometry and response limits
  localparam int TABLE_DEPTH      = 256;
  localparam int MAX_RESULT_ITEMS = 64;
  localparam int IDX_W            = $clog2(TABLE_DEPTH);
  // Absolute address: 16-bit start plus an offset below 2^10
  localparam int ADDR_W           = 17;
  // Result counter: holds 0 .. MAX_RESULT_ITEMS
  localparam int N_W              = $clog2(MAX_RESULT_ITEMS + 1);
  // Bit position counter: holds 0 .. 8*MAX_RESULT_ITEMS, at least 4 bits
  localparam int POS_W_RAW        = $clog2(MAX_RESULT_ITEMS * 8 + 1);
  localparam int POS_W            = (POS_W_RAW < 4) ? 4 : POS_W_RAW;

  localparam int LIMIT_W          = 9;
  localparam int DATA_W           = 16;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  // Frame overheads in bytes
  localparam int READ_OVERHEAD    = 9;
  localparam int WRITE_FRAME      = 12;
  localparam int COILS_PER_BYTE   = 8;

  localparam logic [LIMIT_W-1:0] ADDRESS_LIMIT_RESET = LIMIT_W'(200);

  // Register index (taken from paddr bit 2)
  localparam logic REG_ADDRESS_LIMIT = 1'b0;

  // Request kinds; codes 6 and 7 are ignored
  typedef enum logic [2:0] {
    KIND_RD_BITS  = 3'd0,
    KIND_RD_WORDS = 3'd1,
    KIND_WR_BIT   = 3'd2,
    KIND_WR_WORD  = 3'd3,
    KIND_WR_BITS  = 3'd4,
    KIND_WR_WORDS = 3'd5
  } kind_e;

  // Read request to the tables: entry index and in-range flag
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ok;
  } tbl_rd_t;

  // Write request to the tables
  typedef struct packed {
    logic              word_en;
    logic              bit_en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] word;
    logic              bit_val;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mrms_tables.sv
// Coil and holding-register tables: two synchronous memories with registered
// read data, cleared by a pass over all entries after reset. Uses mrms_pkg.
`default_nettype none

module mrms_tables (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mrms_pkg::tbl_rd_t               rd_i,
  input  wire mrms_pkg::tbl_wr_t               wr_i,
  output logic [mrms_pkg::DATA_W-1:0]          rd_word_o,
  output logic                                 rd_bit_o,
  output logic                                 busy_o
);
  import mrms_pkg::*;

  logic [DATA_W-1:0] word_mem [TABLE_DEPTH];
  logic              bit_mem  [TABLE_DEPTH];

  logic [IDX_W-1:0]  clr_idx_q;
  logic              clr_busy_q;

  logic              word_en;
  logic              bit_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [DATA_W-1:0] wr_word;
  logic              wr_bit;

  logic [DATA_W-1:0] word_q;
  logic              bit_q;
  logic              ok_q;

  // Walk every entry once after reset, one a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = clr_busy_q;

  // Write port: the clearing pass takes it over while it runs
  assign word_en = clr_busy_q | wr_i.word_en;
  assign bit_en  = clr_busy_q | wr_i.bit_en;
  assign wr_idx  = clr_busy_q ? clr_idx_q : wr_i.idx;
  assign wr_word = clr_busy_q ? '0 : wr_i.word;
  assign wr_bit  = clr_busy_q ? 1'b0 : wr_i.bit_val;

  // Write the memories
  always_ff @(posedge clk_i) begin
    if (word_en) begin
      word_mem[wr_idx] <= wr_word;
    end
    if (bit_en) begin
      bit_mem[wr_idx] <= wr_bit;
    end
  end

  // Read the memories into registers
  always_ff @(posedge clk_i) begin
    word_q <= word_mem[rd_i.idx];
    bit_q  <= bit_mem[rd_i.idx];
  end

  // Register the range gate alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= rd_i.ok;
    end
  end

  assign rd_word_o = ok_q ? word_q : '0;
  assign rd_bit_o  = ok_q & bit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/modbus_register_map_server.sv
// Modbus register map server: read-words issues then sends each word (S_WRD, S_WOUT);
// read-bits reads a byte's coils, one coil read a cycle from the coil memory, then
// sends the packed byte. Single writes pass a store state and then the acknowledge
// state, a coil-byte element likewise. One request is in work at a time; the
// output register lets the next request in while a word waits to be taken.
// After reset a pass clears both tables with the input stalled;
// the limit resets to 200.
`default_nettype none

module modbus_register_map_server (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [2:0]                          kind_i,
  input  wire logic [15:0]                         start_address_i,
  input  wire logic [10:0]                         item_count_i,
  input  wire logic [15:0]                         value_i,
  input  wire logic                                final_req_i,
  // Response channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [15:0]                              data_o,
  output logic [7:0]                               byte_count_o,
  output logic [7:0]                               frame_length_o,
  output logic                                     last_o,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mrms_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [mrms_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mrms_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import mrms_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_BRD  = 9'b000000010,
    S_BACC = 9'b000000100,
    S_BOUT = 9'b000001000,
    S_WRD  = 9'b000010000,
    S_WOUT = 9'b000100000,
    S_MBW  = 9'b001000000,
    S_WWR  = 9'b010000000,
    S_ACK  = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] addr_limit_q;

  kind_e              kind_q, kind_d;
  logic [15:0]        start_q, start_d;
  logic [10:0]        cnt_q, cnt_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [N_W-1:0]     n_q, n_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         acc_q, acc_d;
  logic [7:0]         wbits_q, wbits_d;
  logic [3:0]         wn_q, wn_d;
  logic               ack_q, ack_d;

  logic               out_vld_q, out_vld_d;
  logic [DATA_W-1:0]  out_data_q, out_data_d;
  logic [7:0]         out_bc_q, out_bc_d;
  logic [7:0]         out_fl_q, out_fl_d;
  logic               out_last_q, out_last_d;

  logic               accept;
  logic               slot_free;
  logic               cfg_wr;
  logic [ADDR_W-1:0]  lim;
  logic [POS_W-1:0]   off;
  logic [ADDR_W-1:0]  abs_addr;
  logic               in_range;
  logic [8:0]         nbits_full;
  logic               is_read;
  logic               byte_last;
  logic               word_last;
  logic [7:0]         rd_bc;

  tbl_rd_t            tbl_rd;
  tbl_wr_t            tbl_wr;
  logic [DATA_W-1:0]  rd_word;
  logic               rd_bit;
  logic               tbl_busy;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_ADDRESS_LIMIT);
  assign prdata = (paddr[2] == REG_ADDRESS_LIMIT) ? CFG_DATA_W'(addr_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_limit_q <= ADDRESS_LIMIT_RESET;
    end else if (cfg_wr) begin
      addr_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Effective limit: never beyond the table
  assign lim = (32'(addr_limit_q) > TABLE_DEPTH) ? ADDR_W'(TABLE_DEPTH)
                                                 : ADDR_W'(addr_limit_q);

  // Table address: the accumulate state reads one coil ahead
  assign off      = (state_q == S_BACC) ? pos_q + POS_W'(1) : pos_q;
  assign abs_addr = ADDR_W'(start_q) + ADDR_W'(off);
  assign in_range = abs_addr < lim;

  assign tbl_rd.idx = abs_addr[IDX_W-1:0];
  assign tbl_rd.ok  = in_range;

  assign tbl_wr.idx     = abs_addr[IDX_W-1:0];
  assign tbl_wr.word    = val_q;
  assign tbl_wr.bit_val = wbits_q[pos_q[2:0]];
  assign tbl_wr.word_en = (state_q == S_WWR) & in_range;
  assign tbl_wr.bit_en  = (state_q == S_MBW) & (pos_q[3:0] < wn_q) & in_range;

  mrms_tables u_tables (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (tbl_rd),
    .wr_i      (tbl_wr),
    .rd_word_o (rd_word),
    .rd_bit_o  (rd_bit),
    .busy_o    (tbl_busy)
  );

  // Handshake helpers
  assign in_stall_o = (state_q != S_IDLE) | tbl_busy;
  assign accept     = in_valid_i & ~in_stall_o;
  assign slot_free  = ~out_vld_q | ~out_stall_i;

  assign nbits_full = 9'(({1'b0, item_count_i} + 12'd7) >> 3);
  assign is_read    = (kind_q == KIND_RD_BITS) | (kind_q == KIND_RD_WORDS);
  assign byte_last  = (32'(pos_q[POS_W-1:3]) == 32'(n_q));
  assign word_last  = (32'(pos_q) + 1 == 32'(n_q));
  assign rd_bc      = (kind_q == KIND_RD_WORDS) ? 8'(32'(n_q) * 2) : 8'(n_q);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    start_d    = start_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    n_d        = n_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    wbits_d    = wbits_q;
    wn_d       = wn_q;
    ack_d      = ack_q;
    out_vld_d  = out_vld_q & out_stall_i;
    out_data_d = out_data_q;
    out_bc_d   = out_bc_q;
    out_fl_d   = out_fl_q;
    out_last_d = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = kind_e'(kind_i);
          start_d = start_address_i;
          cnt_d   = item_count_i;
          val_d   = value_i;
          pos_d   = '0;
          acc_d   = '0;
          case (kind_e'(kind_i))
            KIND_RD_BITS: begin
              n_d     = (32'(nbits_full) > MAX_RESULT_ITEMS) ? N_W'(MAX_RESULT_ITEMS)
                                                             : N_W'(nbits_full);
              state_d = (nbits_full == '0) ? S_ACK : S_BRD;
            end
            KIND_RD_WORDS: begin
              n_d     = (32'(item_count_i) > MAX_RESULT_ITEMS) ? N_W'(MAX_RESULT_ITEMS)
                                                               : N_W'(item_count_i);
              state_d = (item_count_i == '0) ? S_ACK : S_WRD;
            end
            KIND_WR_BIT: begin
              wbits_d = {7'd0, |value_i};
              wn_d    = 4'd1;
              ack_d   = 1'b1;
              state_d = S_MBW;
            end
            KIND_WR_BITS: begin
              wbits_d = value_i[7:0];
              wn_d    = (item_count_i > 11'(COILS_PER_BYTE)) ? 4'(COILS_PER_BYTE)
                                                             : item_count_i[3:0];
              ack_d   = final_req_i;
              state_d = S_MBW;
            end
            KIND_WR_WORD: begin
              ack_d   = 1'b1;
              state_d = S_WWR;
            end
            KIND_WR_WORDS: begin
              ack_d   = final_req_i;
              state_d = S_WWR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Issue the read of the first coil of a byte
      S_BRD: begin
        state_d = S_BACC;
      end

      // Fold in one coil and read the next
      S_BACC: begin
        acc_d[pos_q[2:0]] = rd_bit & (11'(pos_q) < cnt_q);
        pos_d             = pos_q + POS_W'(1);
        if (pos_q[2:0] == 3'd7) begin
          state_d = S_BOUT;
        end
      end

      // Send a packed coil byte
      S_BOUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {8'd0, acc_q};
          out_bc_d   = rd_bc;
          out_fl_d   = rd_bc + 8'(READ_OVERHEAD);
          out_last_d = byte_last;
          acc_d      = '0;
          state_d    = byte_last ? S_IDLE : S_BRD;
        end
      end

      // Issue a word read
      S_WRD: begin
        state_d = S_WOUT;
      end

      // Send a word; the address holds so the read data stays put
      S_WOUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_data_d = rd_word;
          out_bc_d   = rd_bc;
          out_fl_d   = rd_bc + 8'(READ_OVERHEAD);
          out_last_d = word_last;
          pos_d      = pos_q + POS_W'(1);
          state_d    = word_last ? S_IDLE : S_WRD;
        end
      end

      // Store coils one a cycle
      S_MBW: begin
        if (pos_q[3:0] < wn_q) begin
          pos_d = pos_q + POS_W'(1);
        end else begin
          state_d = ack_q ? S_ACK : S_IDLE;
        end
      end

      // Store one word
      S_WWR: begin
        state_d = ack_q ? S_ACK : S_IDLE;
      end

      // Send a write acknowledge or an empty read
      S_ACK: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_data_d = is_read ? '0 : val_q;
          out_bc_d   = '0;
          out_fl_d   = is_read ? 8'(READ_OVERHEAD) : 8'(WRITE_FRAME);
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    start_q    <= start_d;
    cnt_q      <= cnt_d;
    val_q      <= val_d;
    n_q        <= n_d;
    pos_q      <= pos_d;
    acc_q      <= acc_d;
    wbits_q    <= wbits_d;
    wn_q       <= wn_d;
    ack_q      <= ack_d;
    out_data_q <= out_data_d;
    out_bc_q   <= out_bc_d;
    out_fl_q   <= out_fl_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_vld_q;
  assign data_o         = out_data_q;
  assign byte_count_o   = out_bc_q;
  assign frame_length_o = out_fl_q;
  assign last_o         = out_last_q;

  // Checks
  a_wr_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_wr.word_en || tbl_wr.bit_en) |-> (state_q != S_IDLE))
    else $error("table written while idle");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_wr.word_en || tbl_wr.bit_en) |->
      !(state_q == S_BRD || state_q == S_BACC || state_q == S_WRD || state_q == S_WOUT))
    else $error("table write overlaps a read sequence");

  a_frame_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_bc_q != 8'd0) |-> (out_fl_q == out_bc_q + 8'(READ_OVERHEAD)))
    else $error("read frame length does not match byte count");

  a_frame_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_bc_q == 8'd0) |->
      (out_last_q && (out_fl_q == 8'(READ_OVERHEAD) || out_fl_q == 8'(WRITE_FRAME))))
    else $error("bad empty-read or acknowledge word");

  a_byte_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BOUT) |-> (32'(pos_q[POS_W-1:3]) <= 32'(n_q)))
    else $error("coil byte index past clamped count");

endmodule

`default_nettype wire

FILE: tb/sv/tb_modbus_register_map_server.sv
// Self-checking testbench for modbus_register_map_server: a register map predictor
// scores every response word, with tasks that drive requests and the APB port.
// Depends on mrms_pkg and the modbus_register_map_server RTL.
`default_nettype none

module tb_modbus_register_map_server;
  import mrms_pkg::*;

  localparam int          RAND_ITEMS     = 330;
  localparam int          PHASES         = 7;
  localparam int          SETTLE_CYCLES  = 50;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [2:0]  KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_ADDRESS_LIMIT, 2'b00};

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [10:0] count;
    logic [15:0] value;
    logic        fin;
  } req_t;

  typedef struct packed {
    logic [15:0] data;
    logic [7:0]  byte_count;
    logic [7:0]  frame_length;
    logic        last;
  } resp_t;

  // Mirror of the coil and word tables; holds the responses still due
  class register_map_model;
    logic [15:0]        words [TABLE_DEPTH];
    bit                 coils [TABLE_DEPTH];
    logic [LIMIT_W-1:0] limit;
    resp_t              due_responses [$];
    int                 mismatches;

    function new();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        words[k] = '0;
        coils[k] = 1'b0;
      end
      limit = ADDRESS_LIMIT_RESET;
      mismatches = 0;
    endfunction

    function int unsigned eff_limit();
      return (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] lim);
      limit = lim;
    endfunction

    function int pending();
      return due_responses.size();
    endfunction

    function void queue_resp(logic [15:0] data, int unsigned bc, int unsigned fl, bit last);
      resp_t r;
      r.data         = data;
      r.byte_count   = bc[7:0];
      r.frame_length = fl[7:0];
      r.last         = last;
      due_responses.push_back(r);
    endfunction

    // Apply one accepted request to the tables and queue its responses
    function void note_request(req_t r);
      int unsigned lim, n, bc, addr, bit_no, i, j;
      logic [15:0] w;
      lim = eff_limit();
      case (r.kind)
        KIND_RD_BITS, KIND_RD_WORDS: begin
          if (r.kind == KIND_RD_BITS) n = (int'(r.count) + 7) / COILS_PER_BYTE;
          else n = r.count;
          if (n > MAX_RESULT_ITEMS) n = MAX_RESULT_ITEMS;
          if (n == 0) begin
            queue_resp('0, 0, READ_OVERHEAD, 1'b1);
          end else begin
            bc = (r.kind == KIND_RD_BITS) ? n : 2 * n;
            for (i = 0; i < n; i++) begin
              w = '0;
              if (r.kind == KIND_RD_BITS) begin
                for (j = 0; j < COILS_PER_BYTE; j++) begin
                  bit_no = i * COILS_PER_BYTE + j;
                  addr   = r.start + bit_no;
                  if (bit_no < r.count && addr < lim && coils[addr]) w[j] = 1'b1;
                end
              end else begin
                addr = r.start + i;
                if (addr < lim) w = words[addr];
              end
              queue_resp(w, bc, bc + READ_OVERHEAD, i + 1 == n);
            end
          end
        end
        KIND_WR_BIT: begin
          if (r.start < lim) coils[r.start] = (r.value != 0);
          queue_resp(r.value, 0, WRITE_FRAME, 1'b1);
        end
        KIND_WR_WORD: begin
          if (r.start < lim) words[r.start] = r.value;
          queue_resp(r.value, 0, WRITE_FRAME, 1'b1);
        end
        KIND_WR_BITS: begin
          n = (r.count > COILS_PER_BYTE) ? COILS_PER_BYTE : r.count;
          for (i = 0; i < n; i++) begin
            addr = r.start + i;
            if (addr < lim) coils[addr] = r.value[i];
          end
          if (r.fin) queue_resp(r.value, 0, WRITE_FRAME, 1'b1);
        end
        KIND_WR_WORDS: begin
          if (r.start < lim) words[r.start] = r.value;
          if (r.fin) queue_resp(r.value, 0, WRITE_FRAME, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted response word with the oldest one due
    function void check_response(resp_t got);
      resp_t want;
      if (due_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response: data=%h bc=%0d fl=%0d last=%b",
                   got.data, got.byte_count, got.frame_length, got.last);
        return;
      end
      want = due_responses.pop_front();
      if (got.data != want.data || got.byte_count != want.byte_count ||
          got.frame_length != want.frame_length || got.last != want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("response mismatch: want data=%h bc=%0d fl=%0d last=%b, got data=%h bc=%0d fl=%0d last=%b",
                   want.data, want.byte_count, want.frame_length, want.last,
                   got.data, got.byte_count, got.frame_length, got.last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            kind_i          = '0;
  logic [15:0]           start_address_i = '0;
  logic [10:0]           item_count_i    = '0;
  logic [15:0]           value_i         = '0;
  logic                  final_req_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [15:0]           data_o;
  logic [7:0]            byte_count_o;
  logic [7:0]            frame_length_o;
  logic                  last_o;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr           = '0;
  logic [CFG_DATA_W-1:0] pwdata          = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  register_map_model board = new();
  bit                calm = 1'b0;
  int                sent = 0;
  int                quiet_cycles = 0;

  modbus_register_map_server dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .kind_i, .start_address_i, .item_count_i, .value_i,
    .final_req_i,
    .out_valid_o, .out_stall_i, .data_o, .byte_count_o, .frame_length_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < 16);
  endfunction

  // Stall the response side at random
  always @(negedge clk_i) begin
    out_stall_i <= roll_idle();
  end

  // Score response words and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_response({data_o, byte_count_o, frame_length_o, last_o});
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Present one request word, with a random gap ahead of it; hold until taken
  task automatic send_request(logic [2:0] kind, logic [15:0] start, logic [10:0] count,
                              logic [15:0] value, logic fin);
    req_t r;
    r = '{kind: kind, start: start, count: count, value: value, fin: fin};
    @(negedge clk_i);
    while (roll_idle()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    start_address_i <= start;
    item_count_i    <= count;
    value_i         <= value;
    final_req_i     <= fin;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(r);
    if (kind <= KIND_WR_WORDS) sent++;
  endtask

  // Drop valid and let the block drain before touching the register
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Read the limit register back and compare with the mirror
  task automatic read_limit();
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= LIMIT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != CFG_DATA_W'(board.limit)) begin
      board.mismatches++;
      if (board.mismatches <= MAX_REPORTS)
        $display("limit readback: want %0d got %0d", board.limit, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the limit register through setup and access cycles
  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[LIMIT_W-1:0] = lim;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_limit(lim);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_limit();
  endtask

  // Mostly the populated area, some around the limit, some anywhere
  function automatic logic [15:0] pick_address();
    int unsigned p, lim;
    p   = $urandom_range(0, 99);
    lim = board.eff_limit();
    if (p < 70) return 16'($urandom_range(0, 300));
    if (p < 85) return 16'($urandom_range((lim > 4) ? lim - 4 : 0, lim + 4));
    return 16'($urandom());
  endfunction

  // Mostly short reads, a few that clamp
  function automatic logic [10:0] pick_count();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return 11'($urandom_range(0, 24));
    if (p < 92) return 11'($urandom_range(25, 80));
    return 11'($urandom_range(0, 2000));
  endfunction

  // Issue one random request or one multiple-write sequence
  task automatic send_random_unit();
    int unsigned pick, len, e;
    logic [15:0] base;
    logic [10:0] cnt;
    bit          coil_seq, well_formed, fin;
    pick = $urandom_range(0, 99);
    base = pick_address();
    if (pick < 20) begin
      send_request(KIND_RD_WORDS, base, pick_count(), 16'($urandom()), 1'($urandom()));
    end else if (pick < 40) begin
      send_request(KIND_RD_BITS, base, pick_count(), 16'($urandom()), 1'($urandom()));
    end else if (pick < 50) begin
      send_request(KIND_WR_BIT, base, 11'($urandom()),
                   $urandom_range(0, 1) ? 16'h0 : 16'($urandom()), 1'($urandom()));
    end else if (pick < 60) begin
      send_request(KIND_WR_WORD, base, 11'($urandom()), 16'($urandom()), 1'($urandom()));
    end else if (pick < 95) begin
      len         = $urandom_range(1, 6);
      coil_seq    = $urandom_range(0, 1);
      well_formed = $urandom_range(0, 99) < 80;
      for (e = 0; e < len; e++) begin
        fin = well_formed ? (e + 1 == len) : 1'($urandom());
        if (coil_seq) begin
          if ($urandom_range(0, 19) == 0) cnt = 11'($urandom_range(0, 2000));
          else if ($urandom_range(0, 3) == 0) cnt = 11'($urandom_range(0, 8));
          else cnt = 11'(COILS_PER_BYTE);
          send_request(KIND_WR_BITS, base + 16'(COILS_PER_BYTE * e), cnt,
                       16'($urandom()), fin);
        end else begin
          send_request(KIND_WR_WORDS, base + 16'(e), 11'($urandom()), 16'($urandom()), fin);
        end
      end
    end else if (pick < 98) begin
      send_request($urandom_range(0, 1) ? KIND_WR_BITS : KIND_WR_WORDS, base,
                   11'($urandom_range(0, 10)), 16'($urandom()), 1'($urandom()));
    end else begin
      send_request($urandom_range(0, 1) ? KIND_UNUSED_LO : KIND_UNUSED_HI, base,
                   11'($urandom()), 16'($urandom()), 1'($urandom()));
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits [PHASES];
    int unsigned        per_phase;
    phase_limits = '{9'd256, 9'd0, 9'd511, 9'd8, 9'($urandom_range(0, 511)), 9'd1, 9'd200};
    per_phase = RAND_ITEMS / PHASES + 1;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset limit of 200
    read_limit();
    send_request(KIND_RD_WORDS, 16'd0, 11'd0, 16'h0, 1'b0);
    send_request(KIND_RD_BITS, 16'd0, 11'd0, 16'h0, 1'b1);
    send_request(KIND_WR_WORD, 16'd0, 11'd0, 16'hFFFF, 1'b0);
    send_request(KIND_WR_WORD, 16'd199, 11'd0, 16'hA5A5, 1'b0);
    send_request(KIND_WR_WORD, 16'd200, 11'd0, 16'h1234, 1'b1);
    send_request(KIND_WR_BIT, 16'd0, 11'd0, 16'h0001, 1'b0);
    send_request(KIND_WR_BIT, 16'd7, 11'd0, 16'h8000, 1'b0);
    send_request(KIND_WR_BIT, 16'd3, 11'd0, 16'h0000, 1'b0);
    send_request(KIND_RD_WORDS, 16'd0, 11'd3, 16'h0, 1'b0);
    send_request(KIND_RD_WORDS, 16'd198, 11'd4, 16'h0, 1'b0);
    send_request(KIND_RD_BITS, 16'd0, 11'd9, 16'h0, 1'b0);
    // Multiple writes: only the final element answers
    send_request(KIND_WR_BITS, 16'd10, 11'd8, 16'h00A5, 1'b0);
    send_request(KIND_WR_BITS, 16'd18, 11'd3, 16'hF0FF, 1'b1);
    send_request(KIND_WR_WORDS, 16'd20, 11'd0, 16'h0001, 1'b0);
    send_request(KIND_WR_WORDS, 16'd21, 11'd0, 16'h0002, 1'b1);
    send_request(KIND_RD_WORDS, 16'd20, 11'd2, 16'h0, 1'b0);
    send_request(KIND_RD_BITS, 16'd10, 11'd16, 16'h0, 1'b0);
    // Oversized reads and addresses running off the end
    send_request(KIND_RD_WORDS, 16'd0, 11'd2000, 16'h0, 1'b0);
    send_request(KIND_RD_BITS, 16'hFFFF, 11'd2000, 16'h0, 1'b0);
    send_request(KIND_RD_BITS, 16'd190, 11'd513, 16'h0, 1'b0);
    send_request(KIND_RD_WORDS, 16'hFFFF, 11'd5, 16'h0, 1'b0);
    // Coil elements with no bits and with a count past a byte
    send_request(KIND_WR_BITS, 16'd30, 11'd0, 16'h00FF, 1'b1);
    send_request(KIND_WR_BITS, 16'd40, 11'd2000, 16'h5A3C, 1'b1);
    send_request(KIND_RD_BITS, 16'd28, 11'd24, 16'h0, 1'b0);
    // Unused kinds produce nothing
    send_request(KIND_UNUSED_LO, 16'd0, 11'd1, 16'h1, 1'b1);
    send_request(KIND_UNUSED_HI, 16'd0, 11'd1, 16'h1, 1'b1);

    // Random part, one limit setting per phase; one phase runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_limit(phase_limits[ph]);
      calm = (ph == 2);
      while (sent < per_phase * (ph + 1)) send_random_unit();
    end
    calm = 1'b0;

    wait_idle();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
